>>> src/tbc_pkg.sv
`default_nettype none

package tbc_pkg;

    // Coordinate and arithmetic widths.
    localparam int CW      = 32;
    localparam int DIFF_W  = CW + 1;
    localparam int COF_W   = 2 * DIFF_W + 1;
    localparam int PROD_W  = COF_W + DIFF_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = 24;
    localparam int NUM_W   = ACC_W + FRAC_W;
    localparam int Q_W     = NUM_W + 1;
    localparam int W0_W    = Q_W + 2;
    localparam int OUT_W   = 32;

    // Digit-serial multiplier: DIG_W bits of the second operand per cycle.
    localparam int DIG_W   = 4;
    localparam int DIG_N   = (DIFF_W + DIG_W - 1) / DIG_W;
    localparam int MB_W    = DIG_W * DIG_N;
    localparam int MCNT_W  = $clog2(DIG_N + 1);
    localparam int DCNT_W  = $clog2(NUM_W + 1);

    // Operand select codes: edge matrix, point offset, cofactors.
    localparam int SEL_W = 5;
    localparam logic [SEL_W-1:0] SEL_T = 5'd0;
    localparam logic [SEL_W-1:0] SEL_R = 5'd9;
    localparam logic [SEL_W-1:0] SEL_C = 5'd12;
    localparam logic [SEL_W-1:0] SEL_END = 5'd21;

    // Input operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             v_load;
        logic             q_start;
        logic             ld_a;
        logic             ld_b;
        logic [SEL_W-1:0] sel;
        logic             clr;
        logic             sub;
        logic             st_cof;
        logic [3:0]       cof_idx;
        logic             st_det;
        logic             st_num;
        logic [1:0]       num_idx;
        logic             div_start;
        logic [1:0]       div_idx;
        logic             out_load;
        logic             out_degen;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic det_zero;
        logic out_free;
    } t_sts;

    // Next index modulo three.
    function automatic logic [1:0] inc3(input logic [1:0] x);
        return (x == 2'd2) ? 2'd0 : 2'(x + 2'd1);
    endfunction

    // Flat index of a 3x3 matrix entry.
    function automatic logic [3:0] idx9(input logic [1:0] i, input logic [1:0] j);
        return 4'(4'(i) * 4'd3 + 4'(j));
    endfunction

    // Saturate a wide signed value to the output word.
    function automatic logic [OUT_W-1:0] sat_out(input logic [W0_W-1:0] v);
        logic [W0_W-OUT_W:0] top;
        top = v[W0_W-1:OUT_W-1];
        if ((top == '0) || (top == '1)) begin
            return v[OUT_W-1:0];
        end
        return v[W0_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

>>> src/tbc_div.sv
`default_nettype none

module tbc_div
    import tbc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [ACC_W-1:0] i_num,
    input  wire logic [ACC_W-1:0] i_den,
    output logic                  o_done,
    output logic [Q_W-1:0]        o_quot
);

    logic              r_busy;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_neg;
    logic [NUM_W-1:0]  r_dvd;
    logic [ACC_W-1:0]  r_dvs;
    logic [ACC_W-1:0]  r_rem;

    logic [ACC_W-1:0]  num_mag;
    logic [ACC_W-1:0]  den_mag;
    logic [ACC_W:0]    rem_sh;
    logic              q_bit;
    logic [ACC_W:0]    rem_nx;

    // Magnitudes of the operands at start.
    assign num_mag = i_num[ACC_W-1] ? ACC_W'(-i_num) : i_num;
    assign den_mag = i_den[ACC_W-1] ? ACC_W'(-i_den) : i_den;

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    always_comb begin
        rem_sh = {r_rem, r_dvd[NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dvs});
        rem_nx = q_bit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    // The dividend register fills up with quotient bits from the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_W'(NUM_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[ACC_W-1] ^ i_den[ACC_W-1];
            r_dvd <= {num_mag, {FRAC_W{1'b0}}};
            r_dvs <= den_mag;
            r_rem <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= rem_nx[ACC_W-1:0];
            r_dvd <= {r_dvd[NUM_W-2:0], q_bit};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_neg ? Q_W'(-{1'b0, r_dvd}) : {1'b0, r_dvd};

endmodule

`default_nettype wire

>>> src/tbc_ctrl.sv
`default_nettype none

module tbc_ctrl
    import tbc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_op,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LDA   = 3'd1;
    localparam logic [2:0] S_LDB   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DWAIT = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_phase, n_phase;
    logic [1:0] r_col, n_col;
    logic [1:0] r_row, n_row;
    logic       r_half, n_half;
    logic       r_degen, n_degen;

    logic             acc;
    logic [1:0]       i1, i2, j1, j2, ccol;
    logic [SEL_W-1:0] sel_a, sel_b;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;

    // Operand selection for the current product.
    always_comb begin
        i1   = inc3(r_row);
        i2   = inc3(i1);
        j1   = inc3(r_col);
        j2   = inc3(j1);
        ccol = (r_col == 2'd0) ? 2'd0 : 2'(r_col - 2'd1);
        if (!r_phase) begin
            sel_a = SEL_T + SEL_W'(idx9(i1, r_half ? j2 : j1));
            sel_b = SEL_T + SEL_W'(idx9(i2, r_half ? j1 : j2));
        end else begin
            sel_a = SEL_C + SEL_W'(idx9(r_row, ccol));
            sel_b = (r_col == 2'd0) ? (SEL_T + SEL_W'(idx9(r_row, 2'd0)))
                                    : (SEL_R + SEL_W'(r_row));
        end
    end

    // Sequencer: cofactors, then the four dot products, then three divisions when the determinant is nonzero.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_half  = r_half;
        n_degen = r_degen;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_in_op == OP_QUERY) begin
                        o_cmd.q_start = 1'b1;
                        n_phase = 1'b0;
                        n_col   = 2'd0;
                        n_row   = 2'd0;
                        n_half  = 1'b0;
                        n_state = S_LDA;
                    end else begin
                        o_cmd.v_load = 1'b1;
                    end
                end
            end
            S_LDA: begin
                o_cmd.ld_a = 1'b1;
                o_cmd.sel  = sel_a;
                n_state    = S_LDB;
            end
            S_LDB: begin
                o_cmd.ld_b = 1'b1;
                o_cmd.sel  = sel_b;
                if (!r_phase) begin
                    o_cmd.clr     = !r_half;
                    o_cmd.sub     = r_half;
                    o_cmd.st_cof  = r_half;
                    o_cmd.cof_idx = idx9(r_row, r_col);
                end else begin
                    o_cmd.clr     = (r_row == 2'd0);
                    o_cmd.st_det  = (r_row == 2'd2) && (r_col == 2'd0);
                    o_cmd.st_num  = (r_row == 2'd2) && (r_col != 2'd0);
                    o_cmd.num_idx = 2'(r_col - 2'd1);
                end
                n_state = S_MUL;
            end
            S_MUL: begin
                if (i_sts.mul_done) begin
                    n_state = S_LDA;
                    if (!r_phase) begin
                        n_half = !r_half;
                        if (r_half) begin
                            if (r_row == 2'd2) begin
                                n_row = 2'd0;
                                if (r_col == 2'd2) begin
                                    n_col   = 2'd0;
                                    n_phase = 1'b1;
                                end else begin
                                    n_col = r_col + 2'd1;
                                end
                            end else begin
                                n_row = r_row + 2'd1;
                            end
                        end
                    end else begin
                        if (r_row == 2'd2) begin
                            n_row = 2'd0;
                            if (r_col == 2'd3) begin
                                n_state = S_CHK;
                            end else begin
                                n_col = r_col + 2'd1;
                            end
                        end else begin
                            n_row = r_row + 2'd1;
                        end
                    end
                end
            end
            S_CHK: begin
                n_degen = i_sts.det_zero;
                n_row   = 2'd0;
                n_state = i_sts.det_zero ? S_FIN : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_idx   = r_row;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                o_cmd.div_idx = r_row;
                if (i_sts.div_done) begin
                    if (r_row == 2'd2) begin
                        n_state = S_FIN;
                    end else begin
                        n_row   = r_row + 2'd1;
                        n_state = S_DIV;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_degen = r_degen;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
            r_col   <= 2'd0;
            r_row   <= 2'd0;
            r_half  <= 1'b0;
            r_degen <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_half  <= n_half;
            r_degen <= n_degen;
        end
    end

endmodule

`default_nettype wire

>>> src/tbc_dpath.sv
`default_nettype none

module tbc_dpath
    import tbc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cmd         i_cmd,
    output t_sts              o_sts,
    input  wire logic [1:0]   i_slot,
    input  wire logic [CW-1:0] i_x,
    input  wire logic [CW-1:0] i_y,
    input  wire logic [CW-1:0] i_z,
    input  wire logic         i_out_ready,
    output logic              o_out_valid,
    output logic [OUT_W-1:0]  o_w0,
    output logic [OUT_W-1:0]  o_w1,
    output logic [OUT_W-1:0]  o_w2,
    output logic [OUT_W-1:0]  o_w3,
    output logic              o_degen
);

    logic [CW-1:0]     r_vx [4];
    logic [CW-1:0]     r_vy [4];
    logic [CW-1:0]     r_vz [4];
    logic [DIFF_W-1:0] r_t [9];
    logic [DIFF_W-1:0] r_r [3];
    logic [COF_W-1:0]  r_cof [9];
    logic [ACC_W-1:0]  r_det;
    logic [ACC_W-1:0]  r_num [3];
    logic [Q_W-1:0]    r_q [3];
    logic [W0_W-1:0]   r_w0;

    logic              r_sgn_a;
    logic [COF_W-1:0]  r_mag_a;
    logic [MB_W-1:0]   r_mag_b;
    logic [PROD_W-1:0] r_prod;
    logic [MCNT_W-1:0] r_mcnt;
    logic              r_mbusy;
    logic              r_neg;
    logic              r_clr;
    logic              r_st_cof;
    logic [3:0]        r_cof_idx;
    logic              r_st_det;
    logic              r_st_num;
    logic [1:0]        r_num_idx;
    logic [ACC_W-1:0]  r_acc;

    logic              r_ovalid;
    logic [OUT_W-1:0]  r_ow [4];
    logic              r_odeg;

    logic [COF_W-1:0]  opnd;
    logic [COF_W-1:0]  opnd_mag;
    logic [PROD_W-1:0] pp;
    logic [ACC_W-1:0]  acc_base;
    logic [ACC_W-1:0]  acc_ext;
    logic [ACC_W-1:0]  acc_new;
    logic              mul_done;
    logic              div_done;
    logic [Q_W-1:0]    quot;

    // Vertex stores; the edge matrix and point offset are formed at query start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 4; s++) begin
                r_vx[s] <= '0;
                r_vy[s] <= '0;
                r_vz[s] <= '0;
            end
        end else if (i_cmd.v_load) begin
            r_vx[i_slot] <= i_x;
            r_vy[i_slot] <= i_y;
            r_vz[i_slot] <= i_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            for (int k = 0; k < 3; k++) begin
                r_t[k]     <= DIFF_W'($signed(r_vx[k+1])) - DIFF_W'($signed(r_vx[0]));
                r_t[3 + k] <= DIFF_W'($signed(r_vy[k+1])) - DIFF_W'($signed(r_vy[0]));
                r_t[6 + k] <= DIFF_W'($signed(r_vz[k+1])) - DIFF_W'($signed(r_vz[0]));
            end
            r_r[0] <= DIFF_W'($signed(i_x)) - DIFF_W'($signed(r_vx[0]));
            r_r[1] <= DIFF_W'($signed(i_y)) - DIFF_W'($signed(r_vy[0]));
            r_r[2] <= DIFF_W'($signed(i_z)) - DIFF_W'($signed(r_vz[0]));
        end
    end

    // Single operand read port over matrix, offset and cofactors.
    always_comb begin
        opnd = '0;
        if (i_cmd.sel < SEL_R) begin
            opnd = COF_W'($signed(r_t[i_cmd.sel[3:0]]));
        end else if (i_cmd.sel < SEL_C) begin
            opnd = COF_W'($signed(r_r[2'(i_cmd.sel - SEL_R)]));
        end else if (i_cmd.sel < SEL_END) begin
            opnd = r_cof[4'(i_cmd.sel - SEL_C)];
        end
        opnd_mag = opnd[COF_W-1] ? COF_W'(-opnd) : opnd;
    end

    // Digit-serial multiply, most significant digit first.
    assign pp = PROD_W'(r_mag_a) * PROD_W'(r_mag_b[MB_W-1 -: DIG_W]);
    assign mul_done = r_mbusy && (r_mcnt == '0);

    always_comb begin
        acc_base = r_clr ? '0 : r_acc;
        acc_ext  = ACC_W'(r_prod);
        acc_new  = r_neg ? (acc_base - acc_ext) : (acc_base + acc_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mcnt  <= '0;
        end else if (i_cmd.ld_b) begin
            r_mbusy <= 1'b1;
            r_mcnt  <= MCNT_W'(DIG_N);
        end else if (r_mbusy) begin
            if (r_mcnt == '0) begin
                r_mbusy <= 1'b0;
            end else begin
                r_mcnt <= r_mcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_a) begin
            r_mag_a <= opnd_mag;
            r_sgn_a <= opnd[COF_W-1];
        end
        if (i_cmd.ld_b) begin
            r_mag_b   <= MB_W'(opnd_mag);
            r_neg     <= r_sgn_a ^ opnd[COF_W-1] ^ i_cmd.sub;
            r_prod    <= '0;
            r_clr     <= i_cmd.clr;
            r_st_cof  <= i_cmd.st_cof;
            r_cof_idx <= i_cmd.cof_idx;
            r_st_det  <= i_cmd.st_det;
            r_st_num  <= i_cmd.st_num;
            r_num_idx <= i_cmd.num_idx;
        end else if (r_mbusy && (r_mcnt != '0)) begin
            r_prod  <= PROD_W'(r_prod << DIG_W) + pp;
            r_mag_b <= r_mag_b << DIG_W;
        end
        if (mul_done) begin
            r_acc <= acc_new;
            if (r_st_cof) begin
                r_cof[r_cof_idx] <= acc_new[COF_W-1:0];
            end
            if (r_st_det) begin
                r_det <= acc_new;
            end
            if (r_st_num) begin
                r_num[r_num_idx] <= acc_new;
            end
        end
    end

    // Shared divider for the three ratios.
    tbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num[i_cmd.div_idx]),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // Weight of vertex 0 is built up as each quotient arrives.
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_w0 <= W0_W'(1) << FRAC_W;
        end else if (div_done) begin
            r_q[i_cmd.div_idx] <= quot;
            r_w0 <= r_w0 - W0_W'($signed(quot));
        end
    end

    // Output register; it holds until the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odeg <= i_cmd.out_degen;
            if (i_cmd.out_degen) begin
                for (int k = 0; k < 4; k++) begin
                    r_ow[k] <= '0;
                end
            end else begin
                r_ow[0] <= sat_out(r_w0);
                r_ow[1] <= sat_out(W0_W'($signed(r_q[0])));
                r_ow[2] <= sat_out(W0_W'($signed(r_q[1])));
                r_ow[3] <= sat_out(W0_W'($signed(r_q[2])));
            end
        end
    end

    assign o_sts.mul_done = mul_done;
    assign o_sts.div_done = div_done;
    assign o_sts.det_zero = (r_det == '0);
    assign o_sts.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_w0        = r_ow[0];
    assign o_w1        = r_ow[1];
    assign o_w2        = r_ow[2];
    assign o_w3        = r_ow[3];
    assign o_degen     = r_odeg;

endmodule

`default_nettype wire

>>> src/tet_barycentric_coords.sv
// Barycentric weights of a point in one stored tetrahedron.
// Input stream: each transfer is either a vertex load (tuser op = 0) that
// writes one of four vertex slots, or a query (op = 1) carrying a point.
// Coordinates are signed Q16.16; the four weights come out signed Q8.24,
// saturated, with a degenerate flag in tuser when the edge determinant is
// zero (the weights are then zero).
// A load produces no output transfer. A query runs on one shared
// digit-serial multiplier (4 bits per cycle) and one restoring divider
// (1 bit per cycle): 30 products form the nine cofactors and four
// determinants, then three 126-step divisions follow unless the
// tetrahedron is degenerate. One query is in flight at a time, so a new
// query is not accepted until the previous one has been handed to the
// output register.
// The output is registered: a finished result waits there while the input
// side accepts loads again; a following query stalls only at its end if
// the previous result has not yet been taken.
// Reset clears all vertices to zero and empties the output register.
`default_nettype none

module tet_barycentric_coords
    import tbc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,   // coord_x, coord_y, coord_z
    input  wire logic [2:0]   s_axis_tuser,   // op, vertex_slot
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,   // weight0, weight1, weight2, weight3
    output logic [0:0]        m_axis_tuser    // degenerate
);

    t_cmd cmd;
    t_sts sts;
    logic [OUT_W-1:0] w0, w1, w2, w3;
    logic             degen;

    tbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tbc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_slot      (s_axis_tuser[2:1]),
        .i_x         (s_axis_tdata[31:0]),
        .i_y         (s_axis_tdata[63:32]),
        .i_z         (s_axis_tdata[95:64]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_w0        (w0),
        .o_w1        (w1),
        .o_w2        (w2),
        .o_w3        (w3),
        .o_degen     (degen)
    );

    assign m_axis_tdata = {w3, w2, w1, w0};
    assign m_axis_tuser = degen;

endmodule

`default_nettype wire
